/* hw/rtl/pbrq_pkg.sv */
// ----------------------------------------------------------------------------
// pbrq_pkg
// Shared types, codes and defaults for the packet buffer ring queue.
// ----------------------------------------------------------------------------
package pbrq_pkg;

   // default geometry
   localparam int SLOT_COUNT_DEF = 8;
   localparam int SLOT_BYTES_DEF = 64;

   // item kinds
   localparam logic [1:0] KIND_APPEND = 2'd0;
   localparam logic [1:0] KIND_PACKET = 2'd1;
   localparam logic [1:0] KIND_READ   = 2'd2;

   // result status codes
   localparam logic [2:0] ST_OK    = 3'd0;
   localparam logic [2:0] ST_BUSY  = 3'd1;
   localparam logic [2:0] ST_LONG  = 3'd2;
   localparam logic [2:0] ST_EMPTY = 3'd3;
   localparam logic [2:0] ST_DATA  = 3'd4;

   // input item
   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data_byte;
      logic       last;
   } req_type;

   // result item
   typedef struct packed {
      logic [2:0] status;
      logic [7:0] read_byte;
      logic [6:0] packet_length;
      logic       run_end;
   } rsp_type;

   // controller states
   typedef enum logic [1:0] {
      S_IDLE,
      S_LOOK,
      S_READ
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;   // latch item, look up slot length
      logic exec;   // carry out the latched item
      logic step;   // emit one byte of a read
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;   // result register can take a new result
      logic stream;     // latched read has a packet with bytes
      logic last_byte;  // read stream is at its final byte
   } stat_type;

endpackage

/* hw/rtl/pbrq_ctrl.sv */
// ----------------------------------------------------------------------------
// pbrq_ctrl
// Sequencer: accepts one item, executes it, and steps read streams.
// ----------------------------------------------------------------------------
module pbrq_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  pbrq_pkg::stat_type  stat,
   output pbrq_pkg::cmd_type   cmd
);

   pbrq_pkg::state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pbrq_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pbrq_pkg::S_IDLE: begin
            if (req_valid) state_in = pbrq_pkg::S_LOOK;
         end
         pbrq_pkg::S_LOOK: begin
            if (stat.out_free) begin
               state_in = stat.stream ? pbrq_pkg::S_READ : pbrq_pkg::S_IDLE;
            end
         end
         pbrq_pkg::S_READ: begin
            if (stat.out_free && stat.last_byte) state_in = pbrq_pkg::S_IDLE;
         end
         default: state_in = pbrq_pkg::S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_stall = 1'b1;
      cmd       = '0;
      case (state_ff)
         pbrq_pkg::S_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         pbrq_pkg::S_LOOK: cmd.exec = stat.out_free;
         pbrq_pkg::S_READ: cmd.step = stat.out_free;
         default: req_stall = 1'b1;
      endcase
   end

endmodule

/* hw/rtl/pbrq_datapath.sv */
// ----------------------------------------------------------------------------
// pbrq_datapath
// Slot storage, ring pointers, packet state and the result register.
// ----------------------------------------------------------------------------
module pbrq_datapath #(
   parameter int SLOT_COUNT = pbrq_pkg::SLOT_COUNT_DEF,
   parameter int SLOT_BYTES = pbrq_pkg::SLOT_BYTES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  pbrq_pkg::req_type   req_item,
   input  pbrq_pkg::cmd_type   cmd,
   output pbrq_pkg::stat_type  stat,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output pbrq_pkg::rsp_type   rsp_item
);

   localparam int SLOT_W = $clog2(SLOT_COUNT);
   localparam int OFS_W  = (SLOT_BYTES > 1) ? $clog2(SLOT_BYTES) : 1;
   localparam int LEN_W  = $clog2(SLOT_BYTES + 1);
   localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
   localparam int ADDR_W = SLOT_W + OFS_W;
   localparam int DEPTH  = SLOT_COUNT * (2 ** OFS_W);

   // control state
   logic [SLOT_W-1:0]     write_slot_ff, write_slot_in;
   logic [SLOT_W-1:0]     read_slot_ff, read_slot_in;
   logic [CNT_W-1:0]      filled_ff, filled_in;
   logic [LEN_W-1:0]      poff_ff, poff_in;
   logic                  pfail_ff, pfail_in;
   logic [SLOT_COUNT-1:0] comp_ff, comp_in;
   logic [SLOT_COUNT-1:0] lvld_ff, lvld_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // payload state
   pbrq_pkg::req_type     item_ff, item_in;
   logic [LEN_W-1:0]      rd_len_ff, rd_len_in;
   logic [LEN_W-1:0]      rd_idx_ff, rd_idx_in;
   pbrq_pkg::rsp_type     rsp_ff;

   // memories and their read registers
   logic [LEN_W-1:0]      lmem [SLOT_COUNT];
   logic [7:0]            bmem [DEPTH];
   logic [LEN_W-1:0]      lrd_ff;
   logic                  lrdv_ff;
   logic [7:0]            brd_ff;

   // memory ports
   logic                  lw_en;
   logic [SLOT_W-1:0]     lw_addr;
   logic [LEN_W-1:0]      lw_data;
   logic [SLOT_W-1:0]     lr_addr;
   logic                  bw_en;
   logic [ADDR_W-1:0]     bw_addr;
   logic [7:0]            bw_data;
   logic                  br_en;
   logic [ADDR_W-1:0]     br_addr;

   logic                  res_load;
   pbrq_pkg::rsp_type     res;

   logic [SLOT_W-1:0]     w, w_nx, r, r_nx;
   logic [LEN_W-1:0]      cur_len;
   logic [LEN_W-1:0]      poff_nx;
   logic                  pfail_nx;
   logic                  q_full, q_empty, out_free, last_byte;

   // derived values
   assign w        = write_slot_ff;
   assign r        = read_slot_ff;
   assign w_nx     = (w == SLOT_W'(SLOT_COUNT - 1)) ? '0 : w + SLOT_W'(1);
   assign r_nx     = (r == SLOT_W'(SLOT_COUNT - 1)) ? '0 : r + SLOT_W'(1);
   assign cur_len  = lrdv_ff ? lrd_ff : '0;
   assign q_full   = (filled_ff >= CNT_W'(SLOT_COUNT));
   assign q_empty  = (filled_ff == '0);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign last_byte = (rd_idx_ff == LEN_W'(rd_len_ff - LEN_W'(1)));
   assign lr_addr  = (req_item.kind == pbrq_pkg::KIND_READ) ? r : w;

   // status toward the controller
   always_comb begin
      stat.out_free  = out_free;
      stat.stream    = (item_ff.kind == pbrq_pkg::KIND_READ) && !q_empty &&
                       comp_ff[r] && (cur_len != '0);
      stat.last_byte = last_byte;
   end

   // item execution
   always_comb begin
      write_slot_in = write_slot_ff;
      read_slot_in  = read_slot_ff;
      filled_in     = filled_ff;
      poff_in       = poff_ff;
      pfail_in      = pfail_ff;
      comp_in       = comp_ff;
      lvld_in       = lvld_ff;
      item_in       = item_ff;
      rd_len_in     = rd_len_ff;
      rd_idx_in     = rd_idx_ff;
      lw_en         = 1'b0;
      lw_addr       = w;
      lw_data       = '0;
      bw_en         = 1'b0;
      bw_addr       = {w, poff_ff[OFS_W-1:0]};
      bw_data       = item_ff.data_byte;
      br_en         = 1'b0;
      br_addr       = {r, rd_idx_ff[OFS_W-1:0]};
      res_load      = 1'b0;
      res           = '{status: pbrq_pkg::ST_OK, read_byte: 8'd0,
                        packet_length: 7'd0, run_end: 1'b1};
      poff_nx       = poff_ff;
      pfail_nx      = pfail_ff;

      if (cmd.load) item_in = req_item;

      if (cmd.exec) begin
         res_load = 1'b1;
         case (item_ff.kind)
            pbrq_pkg::KIND_APPEND: begin
               if (q_full && comp_ff[w]) begin
                  res.status = pbrq_pkg::ST_BUSY;
               end else if (cur_len >= LEN_W'(SLOT_BYTES)) begin
                  // slot is full: close it and move on
                  comp_in[w]    = 1'b1;
                  write_slot_in = w_nx;
                  if (q_full) begin
                     res.status = pbrq_pkg::ST_BUSY;
                  end else begin
                     filled_in = filled_ff + CNT_W'(1);
                     if (comp_ff[w_nx]) begin
                        res.status = pbrq_pkg::ST_BUSY;
                     end else begin
                        bw_en   = 1'b1;
                        bw_addr = {w_nx, OFS_W'(0)};
                        lw_en   = 1'b1;
                        lw_addr = w_nx;
                        lw_data = LEN_W'(1);
                     end
                  end
               end else begin
                  bw_en   = 1'b1;
                  bw_addr = {w, cur_len[OFS_W-1:0]};
                  lw_en   = 1'b1;
                  lw_addr = w;
                  lw_data = cur_len + LEN_W'(1);
               end
            end
            pbrq_pkg::KIND_PACKET: begin
               if (q_full) begin
                  res.status = pbrq_pkg::ST_BUSY;
               end else if (poff_ff >= LEN_W'(SLOT_BYTES)) begin
                  res.status = pbrq_pkg::ST_LONG;
               end else if (pfail_ff) begin
                  res.status = pbrq_pkg::ST_BUSY;
               end
               if (res.status == pbrq_pkg::ST_OK) begin
                  bw_en   = 1'b1;
                  poff_nx = poff_ff + LEN_W'(1);
               end else begin
                  pfail_nx = 1'b1;
               end
               poff_in  = poff_nx;
               pfail_in = pfail_nx;
               // commit on the final byte unless a byte was refused
               if (item_ff.last) begin
                  if (!pfail_nx) begin
                     lw_en         = 1'b1;
                     lw_addr       = w;
                     lw_data       = poff_nx;
                     comp_in[w]    = 1'b1;
                     write_slot_in = w_nx;
                     filled_in     = filled_ff + CNT_W'(1);
                  end
                  poff_in  = '0;
                  pfail_in = 1'b0;
               end
            end
            pbrq_pkg::KIND_READ: begin
               if (q_empty || !comp_ff[r]) begin
                  res.status = pbrq_pkg::ST_EMPTY;
               end else if (cur_len == '0) begin
                  // empty packet: single result, free slot
                  res.status   = pbrq_pkg::ST_DATA;
                  lw_en        = 1'b1;
                  lw_addr      = r;
                  lw_data      = '0;
                  comp_in[r]   = 1'b0;
                  read_slot_in = r_nx;
                  filled_in    = filled_ff - CNT_W'(1);
               end else begin
                  // start the byte stream
                  res_load  = 1'b0;
                  rd_len_in = cur_len;
                  rd_idx_in = '0;
                  br_en     = 1'b1;
                  br_addr   = {r, OFS_W'(0)};
               end
            end
            default: res.status = pbrq_pkg::ST_OK;
         endcase
      end

      // one byte of a read stream per step
      if (cmd.step) begin
         res_load          = 1'b1;
         res.status        = pbrq_pkg::ST_DATA;
         res.read_byte     = brd_ff;
         res.packet_length = 7'(rd_len_ff);
         res.run_end       = last_byte;
         if (last_byte) begin
            lw_en        = 1'b1;
            lw_addr      = r;
            lw_data      = '0;
            comp_in[r]   = 1'b0;
            read_slot_in = r_nx;
            filled_in    = filled_ff - CNT_W'(1);
         end else begin
            rd_idx_in = rd_idx_ff + LEN_W'(1);
            br_en     = 1'b1;
            br_addr   = {r, rd_idx_in[OFS_W-1:0]};
         end
      end

      if (lw_en) lvld_in[lw_addr] = 1'b1;

      // result register handshake
      rsp_valid_in = rsp_valid_ff;
      if (res_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         write_slot_ff <= '0;
         read_slot_ff  <= '0;
         filled_ff     <= '0;
         poff_ff       <= '0;
         pfail_ff      <= 1'b0;
         comp_ff       <= '0;
         lvld_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         write_slot_ff <= write_slot_in;
         read_slot_ff  <= read_slot_in;
         filled_ff     <= filled_in;
         poff_ff       <= poff_in;
         pfail_ff      <= pfail_in;
         comp_ff       <= comp_in;
         lvld_ff       <= lvld_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      rd_len_ff <= rd_len_in;
      rd_idx_ff <= rd_idx_in;
      if (res_load) rsp_ff <= res;
   end

   // slot length memory, registered read
   always_ff @(posedge clock) begin
      if (lw_en) lmem[lw_addr] <= lw_data;
      if (cmd.load) begin
         lrd_ff  <= lmem[lr_addr];
         lrdv_ff <= lvld_ff[lr_addr];
      end
   end

   // slot byte memory, registered read
   always_ff @(posedge clock) begin
      if (bw_en) bmem[bw_addr] <= bw_data;
      if (br_en) brd_ff <= bmem[br_addr];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

/* hw/rtl/packet_buffer_ring_queue_core.sv */
// ----------------------------------------------------------------------------
// packet_buffer_ring_queue_core
// Ring of packet slots fed by append bytes or whole packets, read out
// oldest complete packet first as a byte stream.
//
//   channel  dir  handshake             payload
//   req      in   req_valid/req_stall   req_item  (kind, data_byte, last)
//   rsp      out  rsp_valid/rsp_stall   rsp_item  (status, read_byte,
//                                                  packet_length, run_end)
//
// Write and empty-read items are accepted, then executed once the registered
// slot length lookup is in and the result register is free.
// A read of an n-byte packet streams one byte per cycle while the result is
// not stalled, from the byte memory's single registered read port.
// Reset clears pointers, counters and per-slot flags at once; no sweep.
// A stalled result holds the sequencer; the next item waits until the
// current one has placed its last result.
// ----------------------------------------------------------------------------
module packet_buffer_ring_queue_core #(
   parameter int SLOT_COUNT = pbrq_pkg::SLOT_COUNT_DEF,
   parameter int SLOT_BYTES = pbrq_pkg::SLOT_BYTES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  pbrq_pkg::req_type  req_item,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output pbrq_pkg::rsp_type  rsp_item
);

   pbrq_pkg::cmd_type  cmd;
   pbrq_pkg::stat_type stat;

   // sequencer
   pbrq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // storage and result path
   pbrq_datapath #(
      .SLOT_COUNT (SLOT_COUNT),
      .SLOT_BYTES (SLOT_BYTES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the packet buffer ring queue core. A shadow copy
// of the slot ring predicts every result as items are queued; a driver and
// a monitor move transfers under random idle and stall, and each result is
// compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int NSLOT       = pbrq_pkg::SLOT_COUNT_DEF;
   localparam int NBYTE       = pbrq_pkg::SLOT_BYTES_DEF;
   localparam int CYCLE_LIMIT = 400000;
   localparam int REPORT_MAX  = 10;

   // the one kind the block treats as a no-op
   localparam logic [1:0] KIND_SPARE = 2'd3;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   pbrq_pkg::req_type req_item = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   pbrq_pkg::rsp_type rsp_item;

   packet_buffer_ring_queue_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   // shadow ring
   logic [7:0]  ring_data [NSLOT*NBYTE];
   bit          ring_seen [NSLOT*NBYTE];   // byte stored at least once
   bit   [6:0]  ring_len  [NSLOT];
   bit          ring_done [NSLOT];
   int unsigned wr_slot, rd_slot, filled, pkt_off;
   bit          pkt_failed;

   pbrq_pkg::req_type items_todo  [$];
   pbrq_pkg::rsp_type results_due [$];
   int unsigned       queued_count = 0;

   int                send_idle_pct = 0;
   int                stall_pct = 0;
   bit                req_taken = 1'b0;
   int                mismatch_count = 0;
   int unsigned       cycles = 0;
   pbrq_pkg::rsp_type want;

   // ------------------------------------------------------------------
   // Shadow ring update, one item at a time
   // ------------------------------------------------------------------
   function automatic logic [2:0] ring_append(input logic [7:0] b);
      int unsigned w;
      w = wr_slot;
      if (filled >= NSLOT && ring_done[w])
         return pbrq_pkg::ST_BUSY;
      // full slot: close it and move on
      if (ring_len[w] >= NBYTE) begin
         ring_done[w] = 1'b1;
         wr_slot = (w + 1) % NSLOT;
         if (filled < NSLOT)
            filled++;
         else
            return pbrq_pkg::ST_BUSY;
         w = wr_slot;
         if (ring_done[w])
            return pbrq_pkg::ST_BUSY;
         ring_len[w] = '0;
      end
      ring_data[w*NBYTE + ring_len[w]] = b;
      ring_seen[w*NBYTE + ring_len[w]] = 1'b1;
      ring_len[w] = ring_len[w] + 7'd1;
      return pbrq_pkg::ST_OK;
   endfunction

   function automatic logic [2:0] ring_packet(input logic [7:0] b, input logic fin);
      logic [2:0]  st;
      int unsigned w;
      w = wr_slot;
      if (filled >= NSLOT)
         st = pbrq_pkg::ST_BUSY;
      else if (pkt_off >= NBYTE)
         st = pbrq_pkg::ST_LONG;
      else if (pkt_failed)
         st = pbrq_pkg::ST_BUSY;
      else
         st = pbrq_pkg::ST_OK;

      if (st == pbrq_pkg::ST_OK) begin
         ring_data[w*NBYTE + pkt_off] = b;
         ring_seen[w*NBYTE + pkt_off] = 1'b1;
         pkt_off++;
      end else begin
         pkt_failed = 1'b1;
      end

      // commit on last unless some byte was refused
      if (fin) begin
         if (!pkt_failed) begin
            ring_len[w] = 7'(pkt_off);
            ring_done[w] = 1'b1;
            wr_slot = (w + 1) % NSLOT;
            filled++;
         end
         pkt_off = 0;
         pkt_failed = 1'b0;
      end
      return st;
   endfunction

   function automatic void ring_apply(input pbrq_pkg::req_type it);
      int unsigned r, n;
      case (it.kind)
         pbrq_pkg::KIND_APPEND:
            results_due.push_back({ring_append(it.data_byte), 8'd0, 7'd0, 1'b1});
         pbrq_pkg::KIND_PACKET:
            results_due.push_back({ring_packet(it.data_byte, it.last),
                                   8'd0, 7'd0, 1'b1});
         pbrq_pkg::KIND_READ: begin
            r = rd_slot;
            if (filled == 0 || !ring_done[r]) begin
               results_due.push_back({pbrq_pkg::ST_EMPTY, 8'd0, 7'd0, 1'b1});
            end else begin
               n = ring_len[r];
               if (n > NBYTE)
                  n = NBYTE;
               if (n == 0)
                  results_due.push_back({pbrq_pkg::ST_DATA, 8'd0, 7'd0, 1'b1});
               else
                  for (int i = 0; i < n; i++)
                     results_due.push_back({pbrq_pkg::ST_DATA, ring_data[r*NBYTE + i],
                                            7'(n), 1'(i + 1 == n)});
               ring_len[r] = '0;
               ring_done[r] = 1'b0;
               rd_slot = (r + 1) % NSLOT;
               filled--;
            end
         end
         default: results_due.push_back({pbrq_pkg::ST_OK, 8'd0, 7'd0, 1'b1});
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Queue one item and its predicted results. A commit whose slot would
   // expose bytes never stored since reset is turned into a plain byte.
   // ------------------------------------------------------------------
   function automatic void queue_item(input logic [1:0] kind, input logic [7:0] b,
                                      input logic last);
      pbrq_pkg::req_type it;
      logic              fin;
      int unsigned       base;
      fin = last;
      if (kind == pbrq_pkg::KIND_PACKET && last && filled < NSLOT && pkt_off < NBYTE
          && !pkt_failed)
      begin
         base = wr_slot * NBYTE;
         for (int i = 0; i < pkt_off; i++)
            if (!ring_seen[base + i])
               fin = 1'b0;
      end
      it = {kind, b, fin};
      items_todo.push_back(it);
      ring_apply(it);
      queued_count++;
   endfunction

   // one random sequence of items
   function automatic void queue_sequence();
      int unsigned pick, n;
      pick = $urandom_range(0, 99);
      if (pick < 38) begin
         // whole packet, mostly short
         n = $urandom_range(0, 99);
         if (n < 82)
            n = $urandom_range(1, 8);
         else if (n < 95)
            n = $urandom_range(9, NBYTE);
         else
            n = $urandom_range(NBYTE + 1, NBYTE + 4);
         for (int i = 1; i <= n; i++)
            queue_item(pbrq_pkg::KIND_PACKET, 8'($urandom_range(0, 255)), 1'(i == n));
      end else if (pick < 58) begin
         // reads
         repeat ($urandom_range(1, 3))
            queue_item(pbrq_pkg::KIND_READ, 8'($urandom_range(0, 255)),
                       1'($urandom_range(0, 1)));
      end else if (pick < 72) begin
         // append run, sometimes long enough to cross a slot
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 10);
         repeat (n)
            queue_item(pbrq_pkg::KIND_APPEND, 8'($urandom_range(0, 255)),
                       1'($urandom_range(0, 1)));
      end else if (pick < 80) begin
         // burst of short packets to push the ring to full
         repeat ($urandom_range(6, 10)) begin
            n = $urandom_range(1, 3);
            for (int i = 1; i <= n; i++)
               queue_item(pbrq_pkg::KIND_PACKET, 8'($urandom_range(0, 255)),
                          1'(i == n));
         end
      end else if (pick < 88) begin
         // packet bytes with no last: the packet runs on into later items
         repeat ($urandom_range(1, 4))
            queue_item(pbrq_pkg::KIND_PACKET, 8'($urandom_range(0, 255)), 1'b0);
      end else begin
         queue_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)));
      end
   endfunction

   // ------------------------------------------------------------------
   // Clock
   // ------------------------------------------------------------------
   initial begin
      forever #10 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Driver: request side and result stall, changed on the falling edge
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      req_taken <= !reset && req_valid && !req_stall;
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_stall <= 1'b0;
      end else begin
         // hold a stalled transfer; otherwise load the next or idle
         if (!req_valid || req_taken) begin
            if (items_todo.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_item  <= items_todo.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   // ------------------------------------------------------------------
   // Monitor: compare each result transfer, watch the cycle limit
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else if (!reset && rsp_valid && !rsp_stall) begin
         if (results_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
               $display("unexpected result: status %0d byte %02h len %0d end %0b",
                        rsp_item.status, rsp_item.read_byte, rsp_item.packet_length,
                        rsp_item.run_end);
         end else begin
            want = results_due.pop_front();
            if (rsp_item.status !== want.status || rsp_item.read_byte !== want.read_byte
                || rsp_item.packet_length !== want.packet_length
                || rsp_item.run_end !== want.run_end) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX)
                  $display("mismatch at cycle %0d: want %0d/%02h/%0d/%0b got %0d/%02h/%0d/%0b",
                           cycles, want.status, want.read_byte, want.packet_length,
                           want.run_end, rsp_item.status, rsp_item.read_byte,
                           rsp_item.packet_length, rsp_item.run_end);
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus and sequencing
   // ------------------------------------------------------------------
   initial begin
      for (int i = 0; i < NSLOT*NBYTE; i++) begin
         ring_data[i] = '0;
         ring_seen[i] = 1'b0;
      end
      for (int i = 0; i < NSLOT; i++) begin
         ring_len[i]  = '0;
         ring_done[i] = 1'b0;
      end
      wr_slot = 0;
      rd_slot = 0;
      filled = 0;
      pkt_off = 0;
      pkt_failed = 1'b0;

      // directed: empty read, spare kind, extremes, interleave, full ring
      queue_item(pbrq_pkg::KIND_READ, 8'h00, 1'b0);
      queue_item(KIND_SPARE, 8'hFF, 1'b1);
      queue_item(pbrq_pkg::KIND_PACKET, 8'h00, 1'b1);
      queue_item(pbrq_pkg::KIND_PACKET, 8'hFF, 1'b0);
      queue_item(pbrq_pkg::KIND_PACKET, 8'hA5, 1'b1);
      queue_item(pbrq_pkg::KIND_READ, 8'hFF, 1'b1);
      queue_item(pbrq_pkg::KIND_READ, 8'h00, 1'b0);
      queue_item(pbrq_pkg::KIND_APPEND, 8'h00, 1'b1);
      queue_item(pbrq_pkg::KIND_APPEND, 8'hFF, 1'b0);
      queue_item(pbrq_pkg::KIND_READ, 8'h5A, 1'b0);     // appended slot not yet complete
      queue_item(pbrq_pkg::KIND_PACKET, 8'h3C, 1'b1);   // packet overwrites appended bytes
      for (int i = 0; i < NSLOT; i++)
         queue_item(pbrq_pkg::KIND_PACKET, 8'(i * 37), 1'b1);   // last one finds the ring full
      queue_item(pbrq_pkg::KIND_APPEND, 8'h5A, 1'b0);   // ring full, slot complete
      queue_item(pbrq_pkg::KIND_READ, 8'h00, 1'b1);

      // no idling
      while (queued_count < 100)
         queue_sequence();

      repeat (7) @(negedge clock);
      reset <= 1'b0;

      while (items_todo.size() != 0)
         @(posedge clock);

      // sender idles
      send_idle_pct = 46;
      stall_pct = 0;
      while (queued_count < 177)
         queue_sequence();
      while (items_todo.size() != 0)
         @(posedge clock);

      // receiver stalls
      send_idle_pct = 0;
      stall_pct = 46;
      while (queued_count < 254)
         queue_sequence();
      while (items_todo.size() != 0)
         @(posedge clock);

      // both
      send_idle_pct = 32;
      stall_pct = 32;
      while (queued_count < 330)
         queue_sequence();
      while (items_todo.size() != 0 || req_valid)
         @(posedge clock);

      // drain
      while (results_due.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);

      if (mismatch_count == 0 && results_due.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

/* filelist.f */
hw/rtl/pbrq_pkg.sv
hw/rtl/pbrq_ctrl.sv
hw/rtl/pbrq_datapath.sv
hw/rtl/packet_buffer_ring_queue_core.sv
tb/tb_top.sv
